>>> rtl/core/luhn_card_classifier_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef LUHN_CARD_CLASSIFIER_UNIT_MACROS_SVH
`define LUHN_CARD_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication
`define LCC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("luhn classifier check failed");

// next-cycle implication
`define LCC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("luhn classifier check failed");

`endif

>>> rtl/core/lcc_pkg.sv
package lcc_pkg;

    localparam int BinW   = 63;
    localparam int DigitN = 19;
    localparam int BcdW   = 4 * DigitN;
    localparam int LenW   = 5;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_INVALID = 2'd0;
    localparam t_kind KIND_VISA    = 2'd1;
    localparam t_kind KIND_MASTER  = 2'd2;
    localparam t_kind KIND_AMEX    = 2'd3;

    localparam logic [LenW-1:0] LEN_VISA_SHORT = 5'd13;
    localparam logic [LenW-1:0] LEN_AMEX       = 5'd15;
    localparam logic [LenW-1:0] LEN_LONG       = 5'd16;

    typedef struct packed {
        t_kind           kind;
        logic            ok;
        logic [LenW-1:0] count;
    } t_scan_res;

endpackage

>>> rtl/core/lcc_bin2bcd.sv
module lcc_bin2bcd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lcc_pkg::BinW-1:0]    i_number,
    output logic                        o_done,
    output logic [lcc_pkg::BcdW-1:0]    o_bcd
);
    import lcc_pkg::*;

    localparam int CntW = $clog2(BinW);

    logic [BinW-1:0] r_bin;
    logic [BcdW-1:0] r_bcd;
    logic [CntW-1:0] r_cnt;
    logic            r_run;
    logic            r_done;
    logic [BcdW-1:0] adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < DigitN; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(BinW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_number;
            r_bcd <= '0;
        end else if (r_run) begin
            r_bin <= {r_bin[BinW-2:0], 1'b0};
            r_bcd <= {adj[BcdW-2:0], r_bin[BinW-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

>>> rtl/core/lcc_luhn_scan.sv
module lcc_luhn_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lcc_pkg::BcdW-1:0]    i_bcd,
    output logic                        o_done,
    output lcc_pkg::t_scan_res          o_res
);
    import lcc_pkg::*;

    logic [BcdW-1:0] r_bcd;
    logic [LenW-1:0] r_idx;
    logic [LenW-1:0] r_len;
    logic [3:0]      r_acc;
    logic [3:0]      r_top;
    logic [3:0]      r_second;
    logic [3:0]      r_prev;
    logic            r_run;
    logic            r_done;

    logic [3:0] dig;
    logic [4:0] dbl;
    logic [3:0] contrib;
    logic [4:0] sum;
    logic [3:0] n_acc;
    t_kind      kind;

    // luhn term and running sum kept modulo ten
    always_comb begin
        dig = r_bcd[3:0];
        dbl = {dig, 1'b0};
        if (r_idx[0]) begin
            if (dbl >= 5'd10) begin
                contrib = 4'(dbl - 5'd9);
            end else begin
                contrib = dbl[3:0];
            end
        end else begin
            contrib = dig;
        end
        sum = {1'b0, r_acc} + {1'b0, contrib};
        if (sum >= 5'd10) begin
            n_acc = 4'(sum - 5'd10);
        end else begin
            n_acc = sum[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_idx <= '0;
            end else if (r_run) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == LenW'(DigitN - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bcd    <= i_bcd;
            r_acc    <= '0;
            r_len    <= '0;
            r_top    <= '0;
            r_second <= '0;
            r_prev   <= '0;
        end else if (r_run) begin
            r_bcd  <= {4'd0, r_bcd[BcdW-1:4]};
            r_acc  <= n_acc;
            r_prev <= dig;
            // highest nonzero digit so far is the leading one
            if (dig != 4'd0) begin
                r_len    <= r_idx + 1'b1;
                r_top    <= dig;
                r_second <= r_prev;
            end
        end
    end

    always_comb begin
        kind = KIND_INVALID;
        if (r_acc == 4'd0) begin
            if ((r_len == LEN_VISA_SHORT || r_len == LEN_LONG) && r_top == 4'd4) begin
                kind = KIND_VISA;
            end else if (r_len == LEN_LONG && r_top == 4'd5
                         && r_second >= 4'd1 && r_second <= 4'd5) begin
                kind = KIND_MASTER;
            end else if (r_len == LEN_AMEX && r_top == 4'd3
                         && (r_second == 4'd4 || r_second == 4'd7)) begin
                kind = KIND_AMEX;
            end
        end
    end

    assign o_done      = r_done;
    assign o_res.kind  = kind;
    assign o_res.ok    = (r_acc == 4'd0);
    assign o_res.count = r_len;

endmodule

>>> rtl/core/luhn_card_classifier_unit.sv
// Luhn card classifier. Each word carries a 63-bit binary card number; the
// result gives the digit count, whether the Luhn sum is a multiple of ten,
// and the card kind (visa, mastercard, amex or invalid). A word passes from
// acceptance through the bit-serial shift-add-3 binary to decimal
// converter, then through the digit scan that walks the decimal digits one
// per cycle, and its result is then loaded into the output register. One
// word is worked on at a time; a finished result sits in the output
// register while the next word is taken in.
module luhn_card_classifier_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lcc_pkg::BinW-1:0]    i_card_number,
    output logic                        o_valid,
    input  logic                        i_ready,
    output lcc_pkg::t_kind              o_card_kind,
    output logic                        o_checksum_ok,
    output logic [lcc_pkg::LenW-1:0]    o_digit_count
);
    import lcc_pkg::*;
    `include "luhn_card_classifier_unit_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_HOLD
    } t_state;

    t_state          r_state;
    logic            accept;
    logic            conv_done;
    logic [BcdW-1:0] bcd;
    logic            scan_done;
    t_scan_res       scan_res;
    logic            slot_free;
    logic            load_out;

    assign o_ready   = (r_state == ST_IDLE);
    assign accept    = i_valid && o_ready;
    assign slot_free = !o_valid || i_ready;
    assign load_out  = (r_state == ST_HOLD || (r_state == ST_SCAN && scan_done)) && slot_free;

    lcc_bin2bcd u_bin2bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_number (i_card_number),
        .o_done   (conv_done),
        .o_bcd    (bcd)
    );

    lcc_luhn_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (conv_done),
        .i_bcd    (bcd),
        .o_done   (scan_done),
        .o_res    (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && !load_out) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN, ST_HOLD: begin
                    if (load_out) begin
                        o_valid       <= 1'b1;
                        o_card_kind   <= scan_res.kind;
                        o_checksum_ok <= scan_res.ok;
                        o_digit_count <= scan_res.count;
                        r_state       <= ST_IDLE;
                    end else if (scan_done) begin
                        r_state <= ST_HOLD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `LCC_ASSERT_IMP(a_conv_done_in_conv, conv_done, r_state == ST_CONV)
    `LCC_ASSERT_IMP(a_scan_done_in_scan, scan_done, r_state == ST_SCAN)
    `LCC_ASSERT_NXT(a_accept_starts_conv, accept, r_state == ST_CONV)
    `LCC_ASSERT_IMP(a_bad_sum_invalid, o_valid && !o_checksum_ok, o_card_kind == KIND_INVALID)

endmodule
